>>> hw/rtl/round_robin_cpu_scheduler_top_macros.svh
// Assertion macros used by the round-robin scheduler checker.
// Depends on nothing; every macro samples clk and is disabled while rst_n is low.
`ifndef ROUND_ROBIN_CPU_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_CPU_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication: when pre holds, post must hold at the same edge.
`define RRCS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication: when pre holds, post must hold at the next edge.
`define RRCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/rrcs_pkg.sv
// Shared types, sizes and codes of the round-robin scheduler.
// Used by rrcs_cell, round_robin_cpu_scheduler_top, rrcs_checker and the testbench.
package rrcs_pkg;

  // Sizing of the process table and the burst field.
  localparam int MAX_PROCS    = 16;
  localparam int BURST_BITS   = 10;
  localparam int QUANT_W      = 10;
  localparam int CLK_W        = 14;
  localparam int BURST_IN_W   = 10;
  localparam int PROC_FIELD_W = 4;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;
  localparam int PROC_W       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W        = $clog2(MAX_PROCS + 1);
  localparam int RUN_W        = (BURST_BITS > QUANT_W) ? BURST_BITS : QUANT_W;
  localparam int SUM_W        = ((RUN_W > CLK_W) ? RUN_W : CLK_W) + 1;
  localparam int CMP_W        = (BURST_BITS > CLK_W) ? BURST_BITS : CLK_W;

  localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);
  localparam logic [CLK_W-1:0]   CLOCK_MAX   = '1;

  // Register index as decoded from paddr[2].
  localparam logic REG_QUANTUM = 1'b0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SLICE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_LOADED   = 2'd0,
    ST_RAN      = 2'd1,
    ST_REJECTED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // One ready-queue slot: the process and its own bookkeeping travel together.
  typedef struct packed {
    logic [PROC_W-1:0]     proc;
    logic [BURST_BITS-1:0] burst;
    logic [BURST_BITS-1:0] remaining;
  } entry_t;

  // Per-cell update controls.
  typedef struct packed {
    logic shift;
    logic load;
    logic requeue;
  } cell_ctrl_t;

  // Fit a process index into the result field (zero-extend or truncate).
  function automatic logic [PROC_FIELD_W-1:0] proc_field(input logic [PROC_W-1:0] p);
    logic [PROC_W+PROC_FIELD_W-1:0] w;
    w = {{PROC_FIELD_W{1'b0}}, p};
    return w[PROC_FIELD_W-1:0];
  endfunction

  // Keep the low BURST_BITS bits of an incoming burst value.
  function automatic logic [BURST_BITS-1:0] burst_keep(input logic [BURST_IN_W-1:0] b);
    logic [BURST_BITS+BURST_IN_W-1:0] w;
    w = {{BURST_BITS{1'b0}}, b};
    return w[BURST_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/rrcs_cell.sv
// One slot of the ready queue chain of the round-robin scheduler.
// Depends on rrcs_pkg for the slot layout and the control struct.
module rrcs_cell (
  input  logic                clk,
  input  rrcs_pkg::cell_ctrl_t ctrl,
  input  rrcs_pkg::entry_t    next_entry,
  input  rrcs_pkg::entry_t    load_entry,
  input  rrcs_pkg::entry_t    requeue_entry,
  output rrcs_pkg::entry_t    entry
);

  rrcs_pkg::entry_t entry_r;
  rrcs_pkg::entry_t entry_nxt;

  // A new load or a requeued process lands at the tail; otherwise the queue moves toward the head.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = load_entry;
    end else if (ctrl.requeue) begin
      entry_nxt = requeue_entry;
    end else if (ctrl.shift) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

>>> hw/rtl/round_robin_cpu_scheduler_top.sv
// Round-robin time-slice scheduler: each transaction is accepted in S_IDLE and
// executed in S_EXEC. The accept cycle reads the head cell of the queue chain and
// compares its remaining work against the quantum; S_EXEC writes the result
// register and, for a slice, advances the clock and shifts the chain by one cell.
// A new transaction is accepted while a result waits in the output register, but
// its S_EXEC step waits until that result has been taken. The ready queue is a
// chain of MAX_PROCS cells; cell 0 is the head and each pop moves every cell one
// step toward it. Depends on rrcs_pkg and rrcs_cell.
module round_robin_cpu_scheduler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input transactions.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [rrcs_pkg::BURST_IN_W-1:0]     in_burst,
  // Result transactions.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [rrcs_pkg::PROC_FIELD_W-1:0]   out_process,
  output logic [rrcs_pkg::CLK_W-1:0]          out_end_time,
  output logic                                out_finished,
  output logic [rrcs_pkg::CLK_W-1:0]          out_waiting_time,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrcs_pkg::ADDR_W-1:0]         paddr,
  input  logic [rrcs_pkg::DATA_W-1:0]         pwdata,
  output logic [rrcs_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int MAX_PROCS  = rrcs_pkg::MAX_PROCS;
  localparam int BURST_BITS = rrcs_pkg::BURST_BITS;
  localparam int QUANT_W    = rrcs_pkg::QUANT_W;
  localparam int CLK_W      = rrcs_pkg::CLK_W;
  localparam int PROC_W     = rrcs_pkg::PROC_W;
  localparam int CNT_W      = rrcs_pkg::CNT_W;
  localparam int RUN_W      = rrcs_pkg::RUN_W;
  localparam int SUM_W      = rrcs_pkg::SUM_W;
  localparam int CMP_W      = rrcs_pkg::CMP_W;
  localparam int DATA_W     = rrcs_pkg::DATA_W;

  // Control state.
  rrcs_pkg::state_t        state_r, state_nxt;
  logic [QUANT_W-1:0]      quantum_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    started_r, started_nxt;
  logic [CLK_W-1:0]        clock_r, clock_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Captured transaction and head precompute.
  rrcs_pkg::opcode_t       op_r;
  logic [BURST_BITS-1:0]   burst_r;
  logic                    fin_r;
  logic [RUN_W-1:0]        run_r;
  logic [BURST_BITS-1:0]   rem_left_r;

  // Result register.
  rrcs_pkg::status_t            status_r, status_nxt;
  logic [rrcs_pkg::PROC_FIELD_W-1:0] proc_r, proc_nxt;
  logic [CLK_W-1:0]             end_r, end_nxt;
  logic                         fin_out_r, fin_out_nxt;
  logic [CLK_W-1:0]             wait_r, wait_nxt;

  logic accept;
  logic exec_fire;
  logic cfg_write;
  logic load_go, shift_go, requeue_go;

  rrcs_pkg::entry_t     cell_q [MAX_PROCS];
  rrcs_pkg::cell_ctrl_t cell_ctrl [MAX_PROCS];
  rrcs_pkg::entry_t     load_entry;
  rrcs_pkg::entry_t     requeue_entry;
  rrcs_pkg::entry_t     head;

  logic [QUANT_W-1:0]   q_eff;
  logic [RUN_W-1:0]     head_rem, q_ext, head_diff;
  logic                 head_fin;
  logic [SUM_W-1:0]     clock_sum;
  logic [CLK_W-1:0]     clock_sat;
  logic [CMP_W-1:0]     clk_cmp, burst_cmp, wait_diff;
  logic [CLK_W-1:0]     wait_calc;
  logic [CNT_W-1:0]     count_m1;

  // Configuration register and read-back.
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == rrcs_pkg::REG_QUANTUM) ? DATA_W'(quantum_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrcs_pkg::QUANT_RESET;
    end else if (cfg_write && paddr[2] == rrcs_pkg::REG_QUANTUM) begin
      quantum_r <= pwdata[QUANT_W-1:0];
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrcs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rrcs_pkg::S_EXEC;
        end
      end
      rrcs_pkg::S_EXEC: begin
        if (exec_fire) begin
          state_nxt = rrcs_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrcs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    exec_fire = 1'b0;
    case (state_r)
      rrcs_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      rrcs_pkg::S_EXEC: begin
        exec_fire = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall  = 1'b1;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Head precompute: decide whether this turn finishes the process.
  assign head      = cell_q[0];
  assign q_eff     = (quantum_r == '0) ? QUANT_W'(1) : quantum_r;
  assign head_rem  = RUN_W'(head.remaining);
  assign q_ext     = RUN_W'(q_eff);
  assign head_fin  = head_rem <= q_ext;
  assign head_diff = head_rem - q_ext;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= rrcs_pkg::opcode_t'(in_opcode);
      burst_r    <= rrcs_pkg::burst_keep(in_burst);
      fin_r      <= head_fin;
      run_r      <= head_fin ? head_rem : q_ext;
      rem_left_r <= head_diff[BURST_BITS-1:0];
    end
  end

  // Clock advance with saturation, and waiting time of a finished process.
  assign clock_sum = SUM_W'(clock_r) + SUM_W'(run_r);
  assign clock_sat = (clock_sum > SUM_W'(rrcs_pkg::CLOCK_MAX)) ?
                     rrcs_pkg::CLOCK_MAX : clock_sum[CLK_W-1:0];
  assign clk_cmp   = CMP_W'(clock_sat);
  assign burst_cmp = CMP_W'(head.burst);
  assign wait_diff = clk_cmp - burst_cmp;
  assign wait_calc = (clk_cmp > burst_cmp) ? wait_diff[CLK_W-1:0] : '0;

  // Execution of the captured transaction.
  always_comb begin
    count_nxt     = count_r;
    started_nxt   = started_r;
    clock_nxt     = clock_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    proc_nxt      = proc_r;
    end_nxt       = end_r;
    fin_out_nxt   = fin_out_r;
    wait_nxt      = wait_r;
    load_go       = 1'b0;
    shift_go      = 1'b0;
    requeue_go    = 1'b0;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
      proc_nxt      = '0;
      end_nxt       = '0;
      fin_out_nxt   = 1'b0;
      wait_nxt      = '0;
      if (op_r == rrcs_pkg::OP_LOAD) begin
        if (started_r || count_r >= CNT_W'(MAX_PROCS)) begin
          status_nxt = rrcs_pkg::ST_REJECTED;
        end else begin
          load_go    = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          status_nxt = rrcs_pkg::ST_LOADED;
          proc_nxt   = rrcs_pkg::proc_field(count_r[PROC_W-1:0]);
        end
      end else begin
        started_nxt = 1'b1;
        if (count_r == '0) begin
          status_nxt = rrcs_pkg::ST_EMPTY;
          end_nxt    = clock_r;
        end else begin
          shift_go    = 1'b1;
          clock_nxt   = clock_sat;
          status_nxt  = rrcs_pkg::ST_RAN;
          proc_nxt    = rrcs_pkg::proc_field(head.proc);
          end_nxt     = clock_sat;
          fin_out_nxt = fin_r;
          if (fin_r) begin
            count_nxt = count_r - CNT_W'(1);
            wait_nxt  = wait_calc;
          end else begin
            requeue_go = 1'b1;
          end
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrcs_pkg::S_IDLE;
      count_r     <= '0;
      started_r   <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      started_r   <= started_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    proc_r    <= proc_nxt;
    end_r     <= end_nxt;
    fin_out_r <= fin_out_nxt;
    wait_r    <= wait_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_process      = proc_r;
  assign out_end_time     = end_r;
  assign out_finished     = fin_out_r;
  assign out_waiting_time = wait_r;

  // Entries written at the tail of the queue.
  assign load_entry.proc          = count_r[PROC_W-1:0];
  assign load_entry.burst         = burst_r;
  assign load_entry.remaining     = burst_r;
  assign requeue_entry.proc       = head.proc;
  assign requeue_entry.burst      = head.burst;
  assign requeue_entry.remaining  = rem_left_r;
  assign count_m1                 = count_r - CNT_W'(1);

  // Queue chain: cell i takes cell i+1 on a pop; the tail cell takes new entries.
  for (genvar gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
    rrcs_pkg::entry_t nbr;
    if (gi == MAX_PROCS - 1) begin : g_last
      assign nbr = cell_q[gi];
    end else begin : g_mid
      assign nbr = cell_q[gi+1];
    end

    assign cell_ctrl[gi].shift   = shift_go;
    assign cell_ctrl[gi].load    = load_go && (count_r == CNT_W'(gi));
    assign cell_ctrl[gi].requeue = requeue_go && (count_m1 == CNT_W'(gi));

    rrcs_cell u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl[gi]),
      .next_entry    (nbr),
      .load_entry    (load_entry),
      .requeue_entry (requeue_entry),
      .entry         (cell_q[gi])
    );
  end

endmodule

>>> hw/rtl/rrcs_checker.sv
// Port-level checker of the round-robin scheduler, bound to its top level.
// Depends on rrcs_pkg and round_robin_cpu_scheduler_top_macros.svh.
`include "round_robin_cpu_scheduler_top_macros.svh"

module rrcs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          out_status,
  input logic [rrcs_pkg::PROC_FIELD_W-1:0]   out_process,
  input logic [rrcs_pkg::CLK_W-1:0]          out_end_time,
  input logic                                out_finished,
  input logic [rrcs_pkg::CLK_W-1:0]          out_waiting_time
);

  // A stalled result transaction keeps its payload.
  `RRCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_process) && $stable(out_end_time) && $stable(out_waiting_time), "stalled result changed")

  // The block works on one transaction at a time, so it is busy right after accepting one.
  `RRCS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a transaction while busy")

  // Load results carry no timing information.
  `RRCS_ASSERT_NOW(a_load_clean, out_valid && (out_status == rrcs_pkg::ST_LOADED || out_status == rrcs_pkg::ST_REJECTED), out_end_time == '0 && !out_finished && out_waiting_time == '0, "load result has timing fields set")

  // Waiting time is reported only for a finished process.
  `RRCS_ASSERT_NOW(a_wait_only_finished, out_valid && !out_finished, out_waiting_time == '0, "waiting time on unfinished slice")

  // A rejected load reports no process.
  `RRCS_ASSERT_NOW(a_reject_no_proc, out_valid && out_status == rrcs_pkg::ST_REJECTED, out_process == '0, "rejected load names a process")

endmodule

bind round_robin_cpu_scheduler_top rrcs_checker u_rrcs_checker (.*);

>>> tb/sv/tb_round_robin_cpu_scheduler_top.sv
// Self-checking testbench for the round-robin CPU scheduler top level.
// Drives load and slice transactions, predicts every result in place and checks them.
// Depends on rrcs_pkg and round_robin_cpu_scheduler_top.
module tb_round_robin_cpu_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rrcs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;

  // One expected result transaction.
  typedef struct {
    status_t                 stat;
    logic [PROC_FIELD_W-1:0] pid;
    logic [CLK_W-1:0]        end_time;
    logic                    done;
    logic [CLK_W-1:0]        waited;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  opcode_t in_opcode;
  logic [BURST_IN_W-1:0] in_burst;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [PROC_FIELD_W-1:0] out_process;
  logic [CLK_W-1:0] out_end_time;
  logic out_finished;
  logic [CLK_W-1:0] out_waiting_time;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  round_robin_cpu_scheduler_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_burst         (in_burst),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_process      (out_process),
    .out_end_time     (out_end_time),
    .out_finished     (out_finished),
    .out_waiting_time (out_waiting_time),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scheduler state as this testbench tracks it.
  logic [QUANT_W-1:0]    quantum_now = QUANT_RESET;
  logic [BURST_BITS-1:0] burst_mem [MAX_PROCS];
  logic [BURST_BITS-1:0] left_mem [MAX_PROCS];
  logic [PROC_W-1:0]     ring_mem [MAX_PROCS];
  logic [PROC_W-1:0]     ring_head = '0;
  logic [CNT_W-1:0]      ring_len = '0;
  logic [CNT_W-1:0]      n_loaded = '0;
  logic [CLK_W-1:0]      clock_now = '0;
  logic                  sliced = 1'b0;

  sched_result_t schedule_q[$];
  int errors = 0;
  int cycles = 0;
  int n_load_ok = 0;
  int n_reject = 0;
  int n_slice = 0;
  int n_complete = 0;
  int n_empty = 0;

  // Sender and receiver pacing.
  int burst_left = 0;
  bit steady = 1'b0;
  int hold_ticket = 0;
  int seen_ticket = 0;
  int hold_left = 0;
  int seg_left = 0;
  int stall_pct = 0;

  // Apply one input transaction to the tracked state and return the result it causes.
  function automatic sched_result_t advance_scheduler(input opcode_t op,
                                                      input logic [BURST_IN_W-1:0] burst);
    sched_result_t r;
    logic [PROC_W-1:0] pid;
    logic [RUN_W-1:0] slice_len;
    logic [RUN_W-1:0] run;
    logic [CLK_W:0] sum;
    r.stat = ST_REJECTED;
    r.pid = '0;
    r.end_time = '0;
    r.done = 1'b0;
    r.waited = '0;
    if (op == OP_LOAD) begin
      // Loads are refused once the table is full or any slice has been seen.
      if (!sliced && n_loaded < MAX_PROCS && ring_len < MAX_PROCS) begin
        burst_mem[n_loaded] = burst[BURST_BITS-1:0];
        left_mem[n_loaded] = burst[BURST_BITS-1:0];
        ring_mem[(int'(ring_head) + int'(ring_len)) % MAX_PROCS] = PROC_W'(n_loaded);
        ring_len++;
        r.stat = ST_LOADED;
        r.pid = PROC_FIELD_W'(n_loaded);
        n_loaded++;
      end
      return r;
    end
    sliced = 1'b1;
    if (ring_len == 0) begin
      r.stat = ST_EMPTY;
      r.end_time = clock_now;
      return r;
    end
    // Pop the head process and run it for one quantum or what is left of it.
    slice_len = (quantum_now == 0) ? RUN_W'(1) : RUN_W'(quantum_now);
    pid = ring_mem[ring_head];
    ring_head = PROC_W'((int'(ring_head) + 1) % MAX_PROCS);
    ring_len--;
    if (left_mem[pid] > slice_len) begin
      run = slice_len;
      left_mem[pid] = left_mem[pid] - BURST_BITS'(slice_len);
    end else begin
      run = RUN_W'(left_mem[pid]);
      left_mem[pid] = '0;
      r.done = 1'b1;
    end
    // The clock saturates instead of wrapping.
    sum = {1'b0, clock_now} + (CLK_W+1)'(run);
    clock_now = (sum > CLOCK_MAX) ? CLOCK_MAX : sum[CLK_W-1:0];
    if (r.done) begin
      r.waited = (clock_now > burst_mem[pid]) ? clock_now - CLK_W'(burst_mem[pid]) : '0;
    end else begin
      ring_mem[(int'(ring_head) + int'(ring_len)) % MAX_PROCS] = pid;
      ring_len++;
    end
    r.stat = ST_RAN;
    r.pid = PROC_FIELD_W'(pid);
    r.end_time = clock_now;
    return r;
  endfunction

  // Offer one transaction, pausing between bursts, and record its expected result.
  task automatic send_job(input opcode_t op, input logic [BURST_IN_W-1:0] burst);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_burst <= burst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    schedule_q.insert(schedule_q.size(), advance_scheduler(op, burst));
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (schedule_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write the quantum register through a setup and an access cycle.
  task automatic write_quantum(input logic [QUANT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({REG_QUANTUM, 2'b00});
    pwdata <= (DATA_W'($urandom()) << QUANT_W) | DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    quantum_now = value;
  endtask

  // Fill the table with extreme and mixed bursts, then overflow it by one.
  task automatic test_table_fill();
    logic [BURST_IN_W-1:0] bursts [10];
    bursts = '{10'd0, 10'd1023, 10'd1, 10'd4, 10'd5, 10'h2AA, 10'h155, 10'd3, 10'd2, 10'd8};
    foreach (bursts[i]) send_job(OP_LOAD, bursts[i]);
    repeat (MAX_PROCS - 10) send_job(OP_LOAD, BURST_IN_W'($urandom_range(0, 1023)));
    send_job(OP_LOAD, '1);
    settle();
  endtask

  // First slices with a written quantum; a load after that must be refused.
  task automatic test_slicing_begins();
    write_quantum(10'd3);
    repeat (3) send_job(OP_SLICE, BURST_IN_W'($urandom_range(0, 1023)));
    send_job(OP_LOAD, 10'd7);
    settle();
  endtask

  // Mostly slice steps with some refused loads mixed in, under one quantum.
  task automatic test_random_slicing(input logic [QUANT_W-1:0] q, input int count,
                                     input bit no_idle);
    write_quantum(q);
    steady = no_idle;
    repeat (count) begin
      if ($urandom_range(0, 99) < 85)
        send_job(OP_SLICE, BURST_IN_W'($urandom()));
      else
        send_job(OP_LOAD, BURST_IN_W'($urandom_range(0, 1023)));
    end
    settle();
    steady = 1'b0;
  endtask

  // Hold the result side off for a long stretch while slices keep coming.
  task automatic test_backpressure();
    hold_ticket++;
    repeat (24) send_job(OP_SLICE, BURST_IN_W'($urandom()));
    settle();
  endtask

  // Result side stall pattern: segments of random length, each with its own stall rate.
  always @(posedge clk) begin
    if (hold_ticket != seen_ticket) begin
      seen_ticket = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (seg_left == 0) begin
      seg_left = $urandom_range(8, 40);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
    end
    seg_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  // Compare each accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (schedule_q.size() == 0) begin
        $display("%0t ns: result transaction with none expected, status %0d", $time,
                 out_status);
        errors++;
      end else begin
        want = schedule_q.pop_front();
        if (out_status !== want.stat) note_mismatch("status", want.stat, out_status);
        if (out_process !== want.pid) note_mismatch("process", want.pid, out_process);
        if (out_end_time !== want.end_time)
          note_mismatch("end_time", want.end_time, out_end_time);
        if (out_finished !== want.done) note_mismatch("finished", want.done, out_finished);
        if (out_waiting_time !== want.waited)
          note_mismatch("waiting_time", want.waited, out_waiting_time);
        case (want.stat)
          ST_LOADED: n_load_ok++;
          ST_REJECTED: n_reject++;
          ST_RAN: begin
            n_slice++;
            if (want.done) n_complete++;
          end
          default: n_empty++;
        endcase
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               schedule_q.size());
      $display("round_robin_cpu_scheduler_top: mismatch");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_LOAD;
    in_burst = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_slicing_begins();
    test_random_slicing(10'd0, 150, 1'b0);
    test_random_slicing(10'd1, 150, 1'b1);
    test_backpressure();
    test_random_slicing(QUANT_W'($urandom_range(2, 40)), 220, 1'b0);
    test_random_slicing(QUANT_W'($urandom_range(41, 1022)), 200, 1'b0);
    test_random_slicing(10'd1023, 230, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d loads, %0d refused loads, %0d slices (%0d completions)",
             n_load_ok, n_reject, n_slice, n_complete);
    $display("and %0d empty-queue steps over quanta 0, 1, 3, mid-range values and 1023.",
             n_empty);
    if (errors == 0) begin
      $display("round_robin_cpu_scheduler_top: match");
    end else begin
      $display("round_robin_cpu_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rrcs_pkg.sv
hw/rtl/rrcs_cell.sv
hw/rtl/round_robin_cpu_scheduler_top.sv
hw/rtl/rrcs_checker.sv
tb/sv/tb_round_robin_cpu_scheduler_top.sv
